>>> hw/rtl/npp_pkg.sv
package npp_pkg;

  // Palette geometry
  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNT_W         = IDX_W + 1;

  // Field widths
  localparam int unsigned COMP_W = 8;
  localparam int unsigned PEN_W  = 8;
  localparam int unsigned CFG_W  = 9;
  localparam int unsigned SQ_W   = 2 * COMP_W;
  localparam int unsigned DIST_W = SQ_W + 2;
  localparam int unsigned WORD_W = PEN_W + 3 * COMP_W;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [PEN_W-1:0]  pen_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    pen_t  pen;
    comp_t red;
    comp_t green;
    comp_t blue;
  } entry_t;

endpackage

>>> hw/rtl/nearest_palette_pen_pair.sv
// Nearest palette pen pair search.
// Input channel (in_valid_i / in_stall_o): one transaction per item. op_i = write
// stores red/green/blue/pen_number at entry_index_i and gives no result; op_i = query
// searches entries 0..min(palette_count, 256)-1 for the color red/green/blue.
// Output channel (out_valid_o / out_stall_i): one transaction per query carrying the
// nearest pen and a second pen for dithering (the runner-up, or the nearest pen again
// when there is no runner-up, an exact match or a clear winner; both 0 on an empty scan).
// Config channel (cfg_valid_i / cfg_ready_o): writes palette_count; always ready. The
// user must write it only while the block is idle; the block does not enforce this.
// Timing: during a query scan the palette memory gives one entry per cycle, followed
// by a read stage, a squaring stage and a compare stage, after which the result
// waits in ST_DONE for the output register. An exact match ends the scan early.
// The block works on one item at a time; in_stall_o is high during a scan and
// while a finished result waits for the output register.
// The output register lets the next item in while an earlier result is still
// stalled downstream.
// Reset: control clears, palette_count becomes 1. Palette contents stay undefined
// until written; queries must only reach written entries.
module nearest_palette_pen_pair (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [npp_pkg::CFG_W-1:0] cfg_data_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [7:0]           entry_index_i,
  input  npp_pkg::comp_t       red_i,
  input  npp_pkg::comp_t       green_i,
  input  npp_pkg::comp_t       blue_i,
  input  npp_pkg::pen_t        pen_number_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output npp_pkg::pen_t        nearest_pen_o,
  output npp_pkg::pen_t        second_pen_o
);
  import npp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  logic [CFG_W-1:0] palette_count_q;

  // query color and scan bounds
  comp_t            q_red_q, q_green_q, q_blue_q;
  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;

  // pipeline: memory read -> squares -> compare
  entry_t     mem [PALETTE_DEPTH];
  entry_t     rd_data_q;
  logic       rd_vld_q, rd_vld_d;
  logic       issue;
  logic [SQ_W-1:0] sq_r_q, sq_g_q, sq_b_q;
  pen_t       sq_pen_q;
  logic       sq_vld_q, sq_vld_d;

  // running search state
  dist_t best_dist_q, best_dist_d, run_dist_q, run_dist_d;
  pen_t  best_pen_q, best_pen_d, run_pen_q, run_pen_d;
  logic  have_best_q, have_best_d, have_run_q, have_run_d, exact_q, exact_d;

  // output register
  logic out_valid_q, out_valid_d;
  pen_t nearest_q, second_q, nearest_d, second_d;

  logic in_acc, out_free, load_out;
  logic [CNT_W-1:0] cnt_sat;
  dist_t cur_dist;
  logic [DIST_W:0] best_x2;
  logic clear_win;

  function automatic logic [SQ_W-1:0] sq_diff(comp_t a, comp_t b);
    comp_t d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign load_out    = (state_q == ST_DONE) && out_free;

  assign cnt_sat = (32'(palette_count_q) > PALETTE_DEPTH) ? CNT_W'(PALETTE_DEPTH)
                                                          : CNT_W'(palette_count_q);
  assign issue = (state_q == ST_SCAN) && (rd_idx_q < scan_cnt_q) && !exact_q;

  assign cur_dist = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);

  // Second pen rule at the end of a scan
  assign best_x2   = {best_dist_q, 1'b0};
  assign clear_win = best_x2 < {1'b0, run_dist_q};

  always_comb begin
    state_d     = state_q;
    scan_cnt_d  = scan_cnt_q;
    rd_idx_d    = rd_idx_q;
    best_dist_d = best_dist_q;
    best_pen_d  = best_pen_q;
    run_dist_d  = run_dist_q;
    run_pen_d   = run_pen_q;
    have_best_d = have_best_q;
    have_run_d  = have_run_q;
    exact_d     = exact_q;
    rd_vld_d    = issue;
    sq_vld_d    = (state_q == ST_SCAN) && rd_vld_q && !exact_q;
    out_valid_d = out_valid_q && out_stall_i;
    nearest_d   = nearest_q;
    second_d    = second_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (op_i == OP_QUERY)) begin
          scan_cnt_d  = cnt_sat;
          rd_idx_d    = '0;
          have_best_d = 1'b0;
          have_run_d  = 1'b0;
          exact_d     = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (sq_vld_q && !exact_q) begin
          if (cur_dist == '0) begin
            best_pen_d  = sq_pen_q;
            have_best_d = 1'b1;
            exact_d     = 1'b1;
          end else if (!have_best_q || cur_dist < best_dist_q) begin
            if (have_best_q) begin
              run_pen_d  = best_pen_q;
              run_dist_d = best_dist_q;
              have_run_d = 1'b1;
            end
            best_dist_d = cur_dist;
            best_pen_d  = sq_pen_q;
            have_best_d = 1'b1;
          end
        end
        // done once a match is found or all entries went through the pipe
        if (exact_q || (!issue && !rd_vld_q && !sq_vld_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          if (!have_best_q) begin
            nearest_d = '0;
            second_d  = '0;
          end else begin
            nearest_d = best_pen_q;
            second_d  = (exact_q || !have_run_q || clear_win) ? best_pen_q : run_pen_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      palette_count_q <= CFG_W'(1);
      rd_vld_q        <= 1'b0;
      sq_vld_q        <= 1'b0;
      have_best_q     <= 1'b0;
      have_run_q      <= 1'b0;
      exact_q         <= 1'b0;
      out_valid_q     <= 1'b0;
      scan_cnt_q      <= '0;
      rd_idx_q        <= '0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      sq_vld_q    <= sq_vld_d;
      have_best_q <= have_best_d;
      have_run_q  <= have_run_d;
      exact_q     <= exact_d;
      out_valid_q <= out_valid_d;
      scan_cnt_q  <= scan_cnt_d;
      rd_idx_q    <= rd_idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        palette_count_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    best_dist_q <= best_dist_d;
    best_pen_q  <= best_pen_d;
    run_dist_q  <= run_dist_d;
    run_pen_q   <= run_pen_d;
    nearest_q   <= nearest_d;
    second_q    <= second_d;
    if (in_acc && (op_i == OP_QUERY)) begin
      q_red_q   <= red_i;
      q_green_q <= green_i;
      q_blue_q  <= blue_i;
    end
    sq_r_q   <= sq_diff(rd_data_q.red, q_red_q);
    sq_g_q   <= sq_diff(rd_data_q.green, q_green_q);
    sq_b_q   <= sq_diff(rd_data_q.blue, q_blue_q);
    sq_pen_q <= rd_data_q.pen;
  end

  // palette memory: one write port (idle writes), one registered read port (scan)
  always_ff @(posedge clk_i) begin
    if (in_acc && (op_i == OP_WRITE) && (32'(entry_index_i) < PALETTE_DEPTH)) begin
      mem[IDX_W'(entry_index_i)] <= '{pen: pen_number_i, red: red_i,
                                      green: green_i, blue: blue_i};
    end
    rd_data_q <= mem[rd_idx_q[IDX_W-1:0]];
  end

  assign out_valid_o   = out_valid_q;
  assign nearest_pen_o = nearest_q;
  assign second_pen_o  = second_q;

endmodule

>>> tb/sv/nearest_palette_pen_pair_tb.sv
`timescale 1ns / 1ps

module nearest_palette_pen_pair_tb;
  import npp_pkg::*;

  // Run control
  localparam int unsigned START_DIST   = 32'h7ffffff;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = PALETTE_DEPTH + 16;
  localparam int unsigned NUM_PHASES   = 13;
  // Worst case: every item waits out both gaps and a full scan, plus the drains.
  localparam int unsigned LIMIT = 4 * (1500 * (2 * 19 + PALETTE_DEPTH + 8)
                                       + 16 * DRAIN_CYCLES + HOLD_CYCLES);

  typedef struct packed {
    logic  op;
    logic [7:0] idx;
    comp_t red;
    comp_t green;
    comp_t blue;
    pen_t  pen;
  } pal_item_t;

  typedef struct packed {
    pen_t nearest;
    pen_t second;
  } pen_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // DUT inputs, all known from time zero
  logic             cfg_valid_i   = 1'b0;
  logic [CFG_W-1:0] cfg_data_i    = '0;
  logic             in_valid_i    = 1'b0;
  logic             op_i          = OP_WRITE;
  logic [7:0]       entry_index_i = '0;
  comp_t            red_i         = '0;
  comp_t            green_i       = '0;
  comp_t            blue_i        = '0;
  pen_t             pen_number_i  = '0;
  logic             out_stall_i   = 1'b0;

  logic cfg_ready_o;
  logic in_stall_o;
  logic out_valid_o;
  pen_t nearest_pen_o;
  pen_t second_pen_o;

  nearest_palette_pen_pair uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .pen_number_i  (pen_number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .nearest_pen_o (nearest_pen_o),
    .second_pen_o  (second_pen_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Scoreboard state
  pal_item_t   pending_items[$];   // queued by the stimulus, popped by the driver
  pen_pair_t   expected_pens[$];   // predicted pen pairs, oldest first
  entry_t      pal_shadow [PALETTE_DEPTH];  // palette as seen at acceptance
  entry_t      pal_plan   [PALETTE_DEPTH];  // palette as seen while generating
  logic [CFG_W-1:0] count_shadow = CFG_W'(1);  // reset value of palette_count

  int unsigned items_sent   = 0;
  int unsigned items_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // Idle control: per-item gaps, with quiet stretches of back-to-back traffic
  bit          tx_busy  = 1'b0;
  bit          tx_quiet = 1'b0;
  int unsigned tx_gap   = 0;
  bit          rx_quiet = 1'b0;
  int unsigned rx_gap   = 0;
  int unsigned rx_seen  = 0;
  bit          hold_off = 1'b0;

  int unsigned phase_count [NUM_PHASES] =
    '{0, 1, 2, 3, 5, 8, 16, 37, 64, 128, 256, 300, 511};
  int unsigned phase_len [NUM_PHASES] =
    '{15, 45, 70, 70, 85, 100, 100, 70, 60, 30, 25, 25, 25};

  function automatic int unsigned pick_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic int unsigned sq_gap(comp_t a, comp_t b);
    int unsigned d;
    d = (a > b) ? (int'(a) - int'(b)) : (int'(b) - int'(a));
    return d * d;
  endfunction

  // Linear scan over entries 0..min(count, PALETTE_DEPTH)-1; strict improvement
  // demotes the old best to runner-up, an exact hit ends the scan.
  function automatic pen_pair_t search_pens(comp_t r, comp_t g, comp_t b);
    int unsigned span, d, best_d, run_d;
    pen_t        best_p, run_p;
    bit          have_best, have_run, exact;
    pen_pair_t   res;
    span      = (32'(count_shadow) > PALETTE_DEPTH) ? PALETTE_DEPTH : 32'(count_shadow);
    best_d    = START_DIST;
    run_d     = START_DIST;
    best_p    = '0;
    run_p     = '0;
    have_best = 1'b0;
    have_run  = 1'b0;
    exact     = 1'b0;
    for (int i = 0; i < span && !exact; i++) begin
      d = sq_gap(pal_shadow[i].red, r) + sq_gap(pal_shadow[i].green, g)
        + sq_gap(pal_shadow[i].blue, b);
      if (d == 0) begin
        best_p    = pal_shadow[i].pen;
        have_best = 1'b1;
        exact     = 1'b1;
      end else if (d < best_d) begin
        if (have_best) begin
          run_p    = best_p;
          run_d    = best_d;
          have_run = 1'b1;
        end
        best_d    = d;
        best_p    = pal_shadow[i].pen;
        have_best = 1'b1;
      end
    end
    // empty scan: both pens zero
    if (!have_best) return '0;
    // exact hit, no runner-up, or clear winner: repeat the nearest pen
    if (exact || !have_run || (best_d * 2) < run_d) run_p = best_p;
    res.nearest = best_p;
    res.second  = run_p;
    return res;
  endfunction

  task automatic push_item(logic op, logic [7:0] idx, comp_t r, comp_t g, comp_t b,
                           pen_t p);
    pal_item_t it;
    it = '{op: op, idx: idx, red: r, green: g, blue: b, pen: p};
    if (op == OP_WRITE) pal_plan[idx] = '{pen: p, red: r, green: g, blue: b};
    pending_items.push_back(it);
  endtask

  // Mix of writes and queries. Most queries aim at a scanned entry, either exactly
  // or a few steps off, so exact hits and close runner-ups are common.
  task automatic gen_items(int unsigned n, int unsigned cnt);
    int unsigned span, kind, j;
    comp_t       r, g, b;
    logic [7:0]  idx;
    span = (cnt > PALETTE_DEPTH) ? PALETTE_DEPTH : cnt;
    repeat (n) begin
      kind = $urandom_range(0, 99);
      r    = comp_t'($urandom);
      g    = comp_t'($urandom);
      b    = comp_t'($urandom);
      idx  = 8'($urandom);
      if (kind < 35) begin
        if (span != 0 && $urandom_range(0, 1) == 0) idx = 8'($urandom_range(0, span - 1));
        // duplicate colors make ties
        if ($urandom_range(0, 4) == 0) begin
          j = $urandom_range(0, PALETTE_DEPTH - 1);
          r = pal_plan[j].red;
          g = pal_plan[j].green;
          b = pal_plan[j].blue;
        end
        push_item(OP_WRITE, idx, r, g, b, pen_t'($urandom));
      end else begin
        if (span != 0 && kind < 85) begin
          j = $urandom_range(0, span - 1);
          r = pal_plan[j].red;
          g = pal_plan[j].green;
          b = pal_plan[j].blue;
          if (kind >= 62) begin
            r = comp_t'(int'(r) + int'($urandom_range(0, 4)) - 2);
            g = comp_t'(int'(g) + int'($urandom_range(0, 4)) - 2);
            b = comp_t'(int'(b) + int'($urandom_range(0, 4)) - 2);
          end
        end
        push_item(OP_QUERY, idx, r, g, b, pen_t'($urandom));
      end
    end
  endtask

  // palette_count may only change with the block idle
  task automatic set_count(logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    count_shadow = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // All items taken, all results back, then room for a trailing write to finish
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || items_taken != items_sent
           || expected_pens.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Input driver: one transaction at a time, gap drawn after each one
  always @(negedge clk_i) begin : drive_items
    logic      next_valid;
    pal_item_t it;
    next_valid = in_valid_i;
    if (tx_busy && items_taken == items_sent) begin
      tx_busy    = 1'b0;
      next_valid = 1'b0;
    end
    if (rst_ni && !tx_busy) begin
      if (tx_gap != 0) begin
        tx_gap--;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        op_i          <= it.op;
        entry_index_i <= it.idx;
        red_i         <= it.red;
        green_i       <= it.green;
        blue_i        <= it.blue;
        pen_number_i  <= it.pen;
        next_valid = 1'b1;
        tx_busy    = 1'b1;
        items_sent++;
        if (items_sent % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
        tx_gap = pick_gap(tx_quiet);
      end
    end
    in_valid_i <= next_valid;
  end

  // Accepted input: update the palette shadow or predict the pen pair
  always @(posedge clk_i) begin : take_items
    if (rst_ni && in_valid_i && !in_stall_o) begin
      items_taken++;
      if (op_i == OP_WRITE) begin
        pal_shadow[entry_index_i] = '{pen: pen_number_i, red: red_i, green: green_i,
                                      blue: blue_i};
      end else begin
        expected_pens.push_back(search_pens(red_i, green_i, blue_i));
      end
    end
  end

  // Output stall: per-result gap, plus the long hold-off
  always @(negedge clk_i) begin : drive_stall
    if (rx_seen != results_seen) begin
      rx_seen = results_seen;
      if (results_seen % 48 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      rx_gap = pick_gap(rx_quiet);
    end else if (rx_gap != 0) begin
      rx_gap--;
    end
    out_stall_i <= hold_off || (rx_gap != 0);
  end

  // Result monitor
  always @(posedge clk_i) begin : check_results
    pen_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_pens.size() == 0) begin
        $display("%0t: result with none expected: expected none, actual %02h/%02h",
                 $time, nearest_pen_o, second_pen_o);
        mismatch_cnt++;
      end else begin
        want = expected_pens.pop_front();
        if (nearest_pen_o !== want.nearest) begin
          $display("%0t: nearest_pen expected %02h actual %02h",
                   $time, want.nearest, nearest_pen_o);
          mismatch_cnt++;
        end
        if (second_pen_o !== want.second) begin
          $display("%0t: second_pen expected %02h actual %02h",
                   $time, want.second, second_pen_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Long receiver hold-off mid-run so the block backs up and stalls its input
  initial begin : long_hold
    wait (items_taken >= 700);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned last_count;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // load the whole palette so no scan ever reads an unwritten slot
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      push_item(OP_WRITE, 8'(i), comp_t'($urandom), comp_t'($urandom), comp_t'($urandom),
                pen_t'($urandom));
    end
    // queries at the reset count of one
    push_item(OP_QUERY, 8'($urandom), pal_plan[0].red, pal_plan[0].green,
              pal_plan[0].blue, pen_t'($urandom));
    push_item(OP_QUERY, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff);
    push_item(OP_QUERY, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00);
    wait_idle();

    // directed: small hand-built palette
    set_count(CFG_W'(4));
    push_item(OP_WRITE, 8'd0,   8'd2,   8'd1,   8'd0,   8'h00);
    push_item(OP_WRITE, 8'd1,   8'd0,   8'd0,   8'd0,   8'ha5);
    push_item(OP_WRITE, 8'd2,   8'd255, 8'd255, 8'd255, 8'hff);
    push_item(OP_WRITE, 8'd3,   8'd255, 8'd255, 8'd255, 8'h7e);  // tie with slot 2
    push_item(OP_WRITE, 8'd255, 8'h5a,  8'hc3,  8'h3c,  8'h5a);
    push_item(OP_QUERY, 8'd0, 8'd1,   8'd0,   8'd0,   8'h00);  // 2*best == runner
    push_item(OP_QUERY, 8'd0, 8'd0,   8'd0,   8'd0,   8'h00);  // exact hit, slot 1
    push_item(OP_QUERY, 8'd0, 8'd2,   8'd1,   8'd0,   8'h00);  // exact hit, first slot
    push_item(OP_QUERY, 8'd0, 8'd255, 8'd255, 8'd255, 8'h00);  // exact hit on the first tied slot
    push_item(OP_QUERY, 8'd0, 8'd254, 8'd255, 8'd255, 8'h00);  // clear winner
    push_item(OP_QUERY, 8'd0, 8'd128, 8'd128, 8'd128, 8'h00);  // close runner-up
    push_item(OP_QUERY, 8'd0, 8'd3,   8'd2,   8'd0,   8'h00);  // first slot stays best
    push_item(OP_QUERY, 8'd0, 8'd0,   8'd255, 8'd0,   8'hff);
    push_item(OP_QUERY, 8'd0, 8'd255, 8'd0,   8'd255, 8'hff);
    push_item(OP_WRITE, 8'd1,   8'd0,   8'd0,   8'd1,   8'h3c);  // overwrite
    push_item(OP_QUERY, 8'd0, 8'd0,   8'd0,   8'd0,   8'h00);
    wait_idle();

    // random phases over a spread of counts, zero and beyond-depth included
    for (int k = 0; k < NUM_PHASES; k++) begin
      set_count(CFG_W'(phase_count[k]));
      gen_items(phase_len[k], phase_count[k]);
      wait_idle();
    end
    last_count = $urandom_range(1, 255);
    set_count(CFG_W'(last_count));
    gen_items(110, last_count);
    wait_idle();

    while (expected_pens.size() != 0) begin
      $display("%0t: missing result: expected %02h/%02h, actual none",
               $time, expected_pens[0].nearest, expected_pens[0].second);
      void'(expected_pens.pop_front());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
